// ----- sv/msgdf_pkg.sv -----
// ----------------------------------------------------------------------------
// msgdf_pkg
// Types, codes and the CRC-32 byte update for the message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package msgdf_pkg;

  // Frame type bytes and header sizes.
  localparam logic [7:0] TYPE_BEGIN  = 8'h01;
  localparam logic [7:0] TYPE_DATA   = 8'h02;
  localparam logic [3:0] BEGIN_BYTES = 4'd9;
  localparam logic [3:0] DATA_BYTES  = 4'd3;
  // Write position just after the last length byte of a BEGIN write.
  localparam logic [3:0] LENGTH_DONE = 4'd5;

  // CRC-32/ISO-HDLC, reflected form.
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Capacity after reset.
  localparam logic [16:0] CAPACITY_RESET = 17'd65536;

  // Depth of the result queue.
  localparam int QDEPTH = 4;

  typedef enum logic [1:0] {
    FT_NONE  = 2'd0,
    FT_BEGIN = 2'd1,
    FT_DATA  = 2'd2,
    FT_OTHER = 2'd3
  } frame_type_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CRC      = 3'd1,
    ST_TOO_BIG  = 3'd2,
    ST_PROTOCOL = 3'd3,
    ST_TIMEOUT  = 3'd4
  } status_t;

  typedef enum logic {
    RK_PAYLOAD = 1'b0,
    RK_STATUS  = 1'b1
  } result_kind_t;

  typedef struct packed {
    result_kind_t rk;
    logic [15:0]  offset;
    logic [7:0]   value;
    status_t      st;
    logic [16:0]  len;
    logic         last;
  } result_t;

  // One byte through the CRC register, bit by bit.
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/message_deframer_crc32.sv -----
// ----------------------------------------------------------------------------
// message_deframer_crc32
// Parses BEGIN and DATA writes, emits payload bytes and one final status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one beat per received byte or
//   timeout event: kind, data_byte, end_of_write. Output channel
//   (out_valid/out_stall) carries result beats: payload bytes with their
//   offset, or a final status with the message length on success.
//   The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the
//   capacity register, always ready; user writes only while idle (unenforced).
// Timing:
//   An input beat is decoded in the cycle it is accepted; its results enter a
//   four-entry result queue and show on the output in the cycle after at the
//   earliest. One input beat is taken per cycle while in_stall is low. A beat
//   that causes a payload byte and a status gives two result beats; the queue
//   absorbs them. in_stall rises while the queue holds over two results, so the
//   rate is set by the output drain: one result per cycle unless out_stall.
// Reset and stall:
//   Reset empties the queue, closes any transfer and sets capacity to 65536.
//   While out_stall is high the head result holds and input is stalled once
//   the queue holds three results.
// ----------------------------------------------------------------------------
`default_nettype none

module message_deframer_crc32
  import msgdf_pkg::*;
#(
  parameter int unsigned MAX_MESSAGE = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_data,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_write,
  // Output channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [15:0]      payload_offset,
  output logic [7:0]       payload_value,
  output logic [2:0]       status,
  output logic [16:0]      message_length,
  output logic             last
);

  // Length counters hold up to MAX_MESSAGE + 1 (the clamped too-big value).
  localparam int          LEN_W  = $clog2(MAX_MESSAGE + 2);
  localparam logic [31:0] MaxLen = 32'(MAX_MESSAGE);
  localparam int          PTR_W  = $clog2(QDEPTH);
  localparam int          CNT_W  = $clog2(QDEPTH + 1);

  // Configuration register.
  logic [16:0] capacity;

  // Transfer and write state.
  logic              in_transfer, in_transfer_next;
  logic [LEN_W-1:0]  declared_length, declared_length_next;
  logic [31:0]       expected_crc, expected_crc_next;
  logic [LEN_W-1:0]  received_count, received_count_next;
  logic [15:0]       next_sequence, next_sequence_next;
  logic [31:0]       running_crc, running_crc_next;
  logic [3:0]        byte_position, byte_position_next;
  frame_type_t       frame_type, frame_type_next;
  logic [31:0]       header_shift, header_shift_next;
  logic              discard_rest, discard_rest_next;

  // Decode results for the current beat.
  logic        in_fire;
  logic        emit_payload;
  logic        emit_status;
  status_t     st_code;
  logic [16:0] flen;
  logic        release_write;
  logic [31:0] hs_new;
  logic [31:0] cap32;
  logic [31:0] declared32;
  logic [15:0] seq;
  logic [7:0]  b;

  // Result queue.
  result_t           q [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  q_count;
  logic              out_fire;
  result_t           payload_res, status_res;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign in_stall  = q_count > CNT_W'(QDEPTH - 2);
  assign b         = data_byte;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Limit in force and the declared length widened for compares.
  assign cap32      = ({15'd0, capacity} < MaxLen) ? {15'd0, capacity} : MaxLen;
  assign declared32 = {{(32 - LEN_W){1'b0}}, declared_length};
  assign hs_new     = {b, header_shift[31:8]};
  assign seq        = {b, header_shift[7:0]};

  // Parse one beat: next state and the results it causes.
  always_comb begin
    in_transfer_next     = in_transfer;
    declared_length_next = declared_length;
    expected_crc_next    = expected_crc;
    received_count_next  = received_count;
    next_sequence_next   = next_sequence;
    running_crc_next     = running_crc;
    byte_position_next   = byte_position;
    frame_type_next      = frame_type;
    header_shift_next    = header_shift;
    discard_rest_next    = discard_rest;
    emit_payload         = 1'b0;
    emit_status          = 1'b0;
    st_code              = ST_OK;
    flen                 = 17'd0;
    release_write        = 1'b0;

    if (kind) begin
      // Timeout closes everything and reports at once.
      emit_status   = 1'b1;
      st_code       = ST_TIMEOUT;
      release_write = 1'b1;
    end else if (discard_rest) begin
      // Skip the rest of a write after a decision.
      if (end_of_write) begin
        byte_position_next = 4'd0;
        frame_type_next    = FT_NONE;
        header_shift_next  = 32'd0;
        discard_rest_next  = 1'b0;
      end
    end else begin
      priority if (byte_position == 4'd0) begin
        // Type byte.
        header_shift_next = 32'd0;
        priority if (b == TYPE_BEGIN) begin
          frame_type_next    = FT_BEGIN;
          byte_position_next = 4'd1;
        end else if (b == TYPE_DATA && in_transfer) begin
          frame_type_next    = FT_DATA;
          byte_position_next = 4'd1;
        end else if (b != TYPE_DATA && in_transfer) begin
          emit_status = 1'b1;
          st_code     = ST_PROTOCOL;
        end else begin
          release_write = 1'b1;
        end
      end else if (frame_type == FT_BEGIN) begin
        // BEGIN header: length then expected CRC, little-endian.
        header_shift_next  = hs_new;
        byte_position_next = byte_position + 4'd1;
        if (byte_position_next == LENGTH_DONE) begin
          declared_length_next = (hs_new > MaxLen) ? LEN_W'(MAX_MESSAGE + 1)
                                                   : hs_new[LEN_W-1:0];
        end else if (byte_position_next == BEGIN_BYTES) begin
          expected_crc_next = hs_new;
          priority if (declared32 > cap32) begin
            emit_status = 1'b1;
            st_code     = ST_TOO_BIG;
          end else if (declared_length == '0) begin
            emit_status = 1'b1;
            st_code     = (hs_new == 32'd0) ? ST_OK : ST_CRC;
          end else begin
            in_transfer_next    = 1'b1;
            received_count_next = '0;
            next_sequence_next  = 16'd0;
            running_crc_next    = CRC_INIT;
            release_write       = 1'b1;
          end
        end
      end else begin
        // DATA write: sequence number, then payload bytes.
        priority if (byte_position == 4'd1) begin
          header_shift_next  = {24'd0, b};
          byte_position_next = 4'd2;
        end else if (byte_position == 4'd2) begin
          if (seq != next_sequence) begin
            emit_status = 1'b1;
            st_code     = ST_PROTOCOL;
          end else begin
            byte_position_next = DATA_BYTES;
          end
        end else if (received_count >= declared_length) begin
          emit_status = 1'b1;
          st_code     = ST_PROTOCOL;
        end else begin
          emit_payload        = 1'b1;
          running_crc_next    = crc_byte(running_crc, b);
          received_count_next = LEN_W'(received_count + 1'b1);
        end
      end

      // End of write: short headers, sequence advance, completion check.
      if (!emit_status && end_of_write && !release_write) begin
        if (frame_type_next == FT_BEGIN) begin
          emit_status = 1'b1;
          st_code     = ST_PROTOCOL;
        end else if (frame_type_next == FT_DATA) begin
          if (byte_position_next < DATA_BYTES) begin
            emit_status = 1'b1;
            st_code     = ST_PROTOCOL;
          end else begin
            next_sequence_next = next_sequence + 16'd1;
            if (received_count_next == declared_length) begin
              emit_status = 1'b1;
              if ((running_crc_next ^ CRC_INIT) == expected_crc) begin
                st_code = ST_OK;
                flen    = 17'(declared_length);
              end else begin
                st_code = ST_CRC;
              end
            end
          end
        end
      end

      if (emit_status) begin
        release_write = 1'b1;
      end

      // Close the write, or skip its remainder.
      if (end_of_write) begin
        byte_position_next = 4'd0;
        frame_type_next    = FT_NONE;
        header_shift_next  = 32'd0;
        discard_rest_next  = 1'b0;
      end else if (release_write) begin
        byte_position_next = 4'd0;
        frame_type_next    = FT_NONE;
        header_shift_next  = 32'd0;
        discard_rest_next  = 1'b1;
      end
    end

    // A final status, or a timeout, leaves the block idle.
    if (emit_status) begin
      in_transfer_next     = 1'b0;
      declared_length_next = '0;
      expected_crc_next    = 32'd0;
      received_count_next  = '0;
      next_sequence_next   = 16'd0;
      running_crc_next     = CRC_INIT;
    end
    if (kind) begin
      byte_position_next = 4'd0;
      frame_type_next    = FT_NONE;
      header_shift_next  = 32'd0;
      discard_rest_next  = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_transfer     <= 1'b0;
      declared_length <= '0;
      expected_crc    <= 32'd0;
      received_count  <= '0;
      next_sequence   <= 16'd0;
      running_crc     <= CRC_INIT;
      byte_position   <= 4'd0;
      frame_type      <= FT_NONE;
      header_shift    <= 32'd0;
      discard_rest    <= 1'b0;
    end else if (in_fire) begin
      in_transfer     <= in_transfer_next;
      declared_length <= declared_length_next;
      expected_crc    <= expected_crc_next;
      received_count  <= received_count_next;
      next_sequence   <= next_sequence_next;
      running_crc     <= running_crc_next;
      byte_position   <= byte_position_next;
      frame_type      <= frame_type_next;
      header_shift    <= header_shift_next;
      discard_rest    <= discard_rest_next;
    end
  end

  // Result beats built from the decode.
  always_comb begin
    payload_res        = '0;
    payload_res.rk     = RK_PAYLOAD;
    payload_res.offset = 16'(received_count);
    payload_res.value  = b;
    payload_res.st     = ST_OK;
    payload_res.last   = !emit_status;
    status_res         = '0;
    status_res.rk      = RK_STATUS;
    status_res.st      = st_code;
    status_res.len     = flen;
    status_res.last    = 1'b1;
  end

  // Queue storage: payload first, then status.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (emit_payload) begin
        q[wr_ptr] <= payload_res;
      end
      if (emit_status) begin
        q[PTR_W'(wr_ptr + {{(PTR_W - 1){1'b0}}, emit_payload})] <= status_res;
      end
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= PTR_W'(wr_ptr + (in_fire ? {{(PTR_W - 1){1'b0}}, emit_payload} : '0)
                        + (in_fire ? {{(PTR_W - 1){1'b0}}, emit_status} : '0));
      rd_ptr  <= PTR_W'(rd_ptr + {{(PTR_W - 1){1'b0}}, out_fire});
      q_count <= CNT_W'(q_count
                        + (in_fire ? {{(CNT_W - 1){1'b0}}, emit_payload} : '0)
                        + (in_fire ? {{(CNT_W - 1){1'b0}}, emit_status} : '0)
                        - {{(CNT_W - 1){1'b0}}, out_fire});
    end
  end

  // Output beat from the queue head.
  assign out_valid      = q_count != '0;
  assign result_kind    = q[rd_ptr].rk;
  assign payload_offset = q[rd_ptr].offset;
  assign payload_value  = q[rd_ptr].value;
  assign status         = q[rd_ptr].st;
  assign message_length = q[rd_ptr].len;
  assign last           = q[rd_ptr].last;

  // Queue never overfills.
  assert property (@(posedge clk) disable iff (rst) q_count <= CNT_W'(QDEPTH))
    else $error("result queue overflow");

  // A timeout always queues a status and closes the transfer.
  assert property (@(posedge clk) disable iff (rst)
    in_fire && kind |=> out_valid && !in_transfer)
    else $error("timeout did not report or close the transfer");

  // A status beat always ends the results of its input.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind |-> last)
    else $error("status beat without last");

  // Skipping a write only happens with the write position cleared.
  assert property (@(posedge clk) disable iff (rst)
    discard_rest |-> byte_position == 4'd0 && frame_type == FT_NONE)
    else $error("discard with a partial header");

  // An open transfer holds a nonzero declared length within the limit, except
  // while a new BEGIN header is being parsed over it.
  assert property (@(posedge clk) disable iff (rst)
    in_transfer && frame_type != FT_BEGIN |-> declared_length != '0 && declared32 <= MaxLen)
    else $error("open transfer with a bad declared length");

endmodule

`default_nettype wire
